/* rtl/rkc_pkg.sv */
// Package for the romaji-to-kana composer: command and kind codes, shared structs,
// the built-in romaji-to-kana ROM as lookup functions and the pending-buffer helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rkc_pkg;

  localparam int KEY_CHARS = 4;
  localparam int KANA_CHARS = 2;

  localparam logic [2:0] CMD_LETTER = 3'd0;
  localparam logic [2:0] CMD_SYMBOL = 3'd1;
  localparam logic [2:0] CMD_BACKSPACE = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;
  localparam logic [2:0] CMD_NONE = 3'd7;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [10:0] COMPOSE_LIMIT = 11'd1024;
  localparam logic [2:0] PEND_FULL = 3'd4;

  localparam logic [15:0] KANA_SMALL_TSU = 16'h3063;
  localparam logic [15:0] KANA_N = 16'h3093;
  localparam logic [15:0] CH_N = 16'h006E;

  typedef logic [KEY_CHARS-1:0][15:0] pend_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] code;
    logic [63:0] raw;
    logic [2:0] rlen;
  } res_t;

  typedef struct packed {
    logic hit;
    logic prefix;
    logic [15:0] kana0;
    logic [15:0] kana1;
  } look_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push_last;
  } ctrl_t;

  typedef struct packed {
    logic fin;
    logic emits;
    logic hold_valid;
    logic out_free;
  } stat_t;

  function automatic look_t kh(logic [15:0] k0, logic [15:0] k1);
    look_t r;
    r.hit = 1'b1;
    r.prefix = 1'b0;
    r.kana0 = k0;
    r.kana1 = k1;
    return r;
  endfunction

  function automatic look_t k1h(logic [15:0] k0);
    return kh(k0, 16'h0000);
  endfunction

  function automatic logic [63:0] pack_pending(pend_t p, logic [2:0] n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (i < int'(n)) r[16*i +: 16] = p[i];
    end
    return r;
  endfunction

  function automatic look_t rom_lookup(pend_t p, logic [2:0] n);
    look_t r;
    logic [31:0] key;
    logic ok;
    r = '0;
    key = '0;
    ok = 1'b1;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (i < int'(n)) begin
        if (p[i][15:8] != 8'h00 || p[i][7:0] == 8'h00) ok = 1'b0;
        key = {key[23:0], p[i][7:0]};
      end
    end
    if (ok) begin
      case (key)
        "a": r = k1h(16'h3042); "i": r = k1h(16'h3044); "u": r = k1h(16'h3046);
        "e": r = k1h(16'h3048); "o": r = k1h(16'h304A);
        "ka": r = k1h(16'h304B); "ki": r = k1h(16'h304D); "ku": r = k1h(16'h304F);
        "ke": r = k1h(16'h3051); "ko": r = k1h(16'h3053);
        "kya": r = kh(16'h304D, 16'h3083); "kyi": r = kh(16'h304D, 16'h3043);
        "kyu": r = kh(16'h304D, 16'h3085); "kye": r = kh(16'h304D, 16'h3047);
        "kyo": r = kh(16'h304D, 16'h3087);
        "qa": r = kh(16'h304F, 16'h3041); "qi": r = kh(16'h304F, 16'h3043);
        "qu": r = k1h(16'h304F); "qe": r = kh(16'h304F, 16'h3047);
        "qo": r = kh(16'h304F, 16'h3049);
        "ga": r = k1h(16'h304C); "gi": r = k1h(16'h304E); "gu": r = k1h(16'h3050);
        "ge": r = k1h(16'h3052); "go": r = k1h(16'h3054);
        "gya": r = kh(16'h304E, 16'h3083); "gyi": r = kh(16'h304E, 16'h3043);
        "gyu": r = kh(16'h304E, 16'h3085); "gye": r = kh(16'h304E, 16'h3047);
        "gyo": r = kh(16'h304E, 16'h3087);
        "sa": r = k1h(16'h3055); "si": r = k1h(16'h3057); "su": r = k1h(16'h3059);
        "se": r = k1h(16'h305B); "so": r = k1h(16'h305D);
        "sya": r = kh(16'h3057, 16'h3083); "syi": r = kh(16'h3057, 16'h3043);
        "syu": r = kh(16'h3057, 16'h3085); "sye": r = kh(16'h3057, 16'h3047);
        "syo": r = kh(16'h3057, 16'h3087);
        "sha": r = kh(16'h3057, 16'h3083); "shi": r = k1h(16'h3057);
        "shu": r = kh(16'h3057, 16'h3085); "she": r = kh(16'h3057, 16'h3047);
        "sho": r = kh(16'h3057, 16'h3087);
        "za": r = k1h(16'h3056); "zi": r = k1h(16'h3058); "zu": r = k1h(16'h305A);
        "ze": r = k1h(16'h305C); "zo": r = k1h(16'h305E);
        "zya": r = kh(16'h3058, 16'h3083); "zyi": r = kh(16'h3058, 16'h3043);
        "zyu": r = kh(16'h3058, 16'h3085); "zye": r = kh(16'h3058, 16'h3047);
        "zyo": r = kh(16'h3058, 16'h3087);
        "ja": r = kh(16'h3058, 16'h3083); "ji": r = k1h(16'h3058);
        "ju": r = kh(16'h3058, 16'h3085); "je": r = kh(16'h3058, 16'h3047);
        "jo": r = kh(16'h3058, 16'h3087);
        "jya": r = kh(16'h3058, 16'h3083); "jyi": r = kh(16'h3058, 16'h3043);
        "jyu": r = kh(16'h3058, 16'h3085); "jye": r = kh(16'h3058, 16'h3047);
        "jyo": r = kh(16'h3058, 16'h3087);
        "ta": r = k1h(16'h305F); "ti": r = k1h(16'h3061); "tu": r = k1h(16'h3064);
        "te": r = k1h(16'h3066); "to": r = k1h(16'h3068);
        "tya": r = kh(16'h3061, 16'h3083); "tyi": r = kh(16'h3061, 16'h3043);
        "tyu": r = kh(16'h3061, 16'h3085); "tye": r = kh(16'h3061, 16'h3047);
        "tyo": r = kh(16'h3061, 16'h3087);
        "cha": r = kh(16'h3061, 16'h3083); "chi": r = k1h(16'h3061);
        "chu": r = kh(16'h3061, 16'h3085); "che": r = kh(16'h3061, 16'h3047);
        "cho": r = kh(16'h3061, 16'h3087);
        "tsa": r = kh(16'h3064, 16'h3041); "tsi": r = kh(16'h3064, 16'h3043);
        "tsu": r = k1h(16'h3064); "tse": r = kh(16'h3064, 16'h3047);
        "tso": r = kh(16'h3064, 16'h3049);
        "tha": r = kh(16'h3066, 16'h3083); "thi": r = kh(16'h3066, 16'h3043);
        "thu": r = kh(16'h3066, 16'h3085); "the": r = kh(16'h3066, 16'h3047);
        "tho": r = kh(16'h3066, 16'h3087);
        "da": r = k1h(16'h3060); "di": r = k1h(16'h3062); "du": r = k1h(16'h3065);
        "de": r = k1h(16'h3067); "do": r = k1h(16'h3069);
        "dya": r = kh(16'h3062, 16'h3083); "dyi": r = kh(16'h3062, 16'h3043);
        "dyu": r = kh(16'h3062, 16'h3085); "dye": r = kh(16'h3062, 16'h3047);
        "dyo": r = kh(16'h3062, 16'h3087);
        "dha": r = kh(16'h3067, 16'h3083); "dhi": r = kh(16'h3067, 16'h3043);
        "dhu": r = kh(16'h3067, 16'h3085); "dhe": r = kh(16'h3067, 16'h3047);
        "dho": r = kh(16'h3067, 16'h3087);
        "na": r = k1h(16'h306A); "ni": r = k1h(16'h306B); "nu": r = k1h(16'h306C);
        "ne": r = k1h(16'h306D); "no": r = k1h(16'h306E);
        "nya": r = kh(16'h306B, 16'h3083); "nyi": r = kh(16'h306B, 16'h3043);
        "nyu": r = kh(16'h306B, 16'h3085); "nye": r = kh(16'h306B, 16'h3047);
        "nyo": r = kh(16'h306B, 16'h3087);
        "nn": r = k1h(16'h3093);
        "ha": r = k1h(16'h306F); "hi": r = k1h(16'h3072); "hu": r = k1h(16'h3075);
        "he": r = k1h(16'h3078); "ho": r = k1h(16'h307B);
        "hya": r = kh(16'h3072, 16'h3083); "hyi": r = kh(16'h3072, 16'h3043);
        "hyu": r = kh(16'h3072, 16'h3085); "hye": r = kh(16'h3072, 16'h3047);
        "hyo": r = kh(16'h3072, 16'h3087);
        "fa": r = kh(16'h3075, 16'h3041); "fi": r = kh(16'h3075, 16'h3043);
        "fu": r = k1h(16'h3075); "fe": r = kh(16'h3075, 16'h3047);
        "fo": r = kh(16'h3075, 16'h3049);
        "ba": r = k1h(16'h3070); "bi": r = k1h(16'h3073); "bu": r = k1h(16'h3076);
        "be": r = k1h(16'h3079); "bo": r = k1h(16'h307C);
        "bya": r = kh(16'h3073, 16'h3083); "byi": r = kh(16'h3073, 16'h3043);
        "byu": r = kh(16'h3073, 16'h3085); "bye": r = kh(16'h3073, 16'h3047);
        "byo": r = kh(16'h3073, 16'h3087);
        "pa": r = k1h(16'h3071); "pi": r = k1h(16'h3074); "pu": r = k1h(16'h3077);
        "pe": r = k1h(16'h307A); "po": r = k1h(16'h307D);
        "pya": r = kh(16'h3074, 16'h3083); "pyi": r = kh(16'h3074, 16'h3043);
        "pyu": r = kh(16'h3074, 16'h3085); "pye": r = kh(16'h3074, 16'h3047);
        "pyo": r = kh(16'h3074, 16'h3087);
        "ma": r = k1h(16'h307E); "mi": r = k1h(16'h307F); "mu": r = k1h(16'h3080);
        "me": r = k1h(16'h3081); "mo": r = k1h(16'h3082);
        "mya": r = kh(16'h307F, 16'h3083); "myi": r = kh(16'h307F, 16'h3043);
        "myu": r = kh(16'h307F, 16'h3085); "mye": r = kh(16'h307F, 16'h3047);
        "myo": r = kh(16'h307F, 16'h3087);
        "ya": r = k1h(16'h3084); "yu": r = k1h(16'h3086); "yo": r = k1h(16'h3088);
        "ye": r = kh(16'h3044, 16'h3047);
        "ra": r = k1h(16'h3089); "ri": r = k1h(16'h308A); "ru": r = k1h(16'h308B);
        "re": r = k1h(16'h308C); "ro": r = k1h(16'h308D);
        "rya": r = kh(16'h308A, 16'h3083); "ryi": r = kh(16'h308A, 16'h3043);
        "ryu": r = kh(16'h308A, 16'h3085); "rye": r = kh(16'h308A, 16'h3047);
        "ryo": r = kh(16'h308A, 16'h3087);
        "wa": r = k1h(16'h308F); "wi": r = kh(16'h3046, 16'h3043);
        "wu": r = k1h(16'h3046); "we": r = kh(16'h3046, 16'h3047);
        "wo": r = k1h(16'h3092);
        "va": r = kh(16'h3094, 16'h3041); "vi": r = kh(16'h3094, 16'h3043);
        "vu": r = k1h(16'h3094); "ve": r = kh(16'h3094, 16'h3047);
        "vo": r = kh(16'h3094, 16'h3049);
        "xa": r = k1h(16'h3041); "xi": r = k1h(16'h3043); "xu": r = k1h(16'h3045);
        "xe": r = k1h(16'h3047); "xo": r = k1h(16'h3049);
        "la": r = k1h(16'h3041); "li": r = k1h(16'h3043); "lu": r = k1h(16'h3045);
        "le": r = k1h(16'h3047); "lo": r = k1h(16'h3049);
        "xya": r = k1h(16'h3083); "xyu": r = k1h(16'h3085); "xyo": r = k1h(16'h3087);
        "lya": r = k1h(16'h3083); "lyu": r = k1h(16'h3085); "lyo": r = k1h(16'h3087);
        "xtu": r = k1h(16'h3063); "ltu": r = k1h(16'h3063); "ltsu": r = k1h(16'h3063);
        "xn": r = k1h(16'h3093);
        default: r = '0;
      endcase
      case (key)
        "k", "q", "g", "s", "z", "j", "t", "c", "d", "n", "h",
        "f", "b", "p", "m", "y", "r", "w", "v", "x", "l",
        "ky", "gy", "sy", "sh", "zy", "jy", "ty", "ch", "ts", "th", "dy",
        "dh", "ny", "hy", "by", "py", "my", "ry", "xy", "ly", "xt", "lt",
        "lts": r.prefix = 1'b1;
        default: r.prefix = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/romaji_kana_composer_top.sv */
// Processing: a key is loaded, then the single rule evaluator steps through its rule passes,
// each emitting at most one result, and the key finishes.
// Throughput: one input at a time; the next transfer is taken once the previous input's
// final result sits in the output register, or once it finishes if it held no result
// (later if the sink stalls).
// Reset (rst, synchronous, active high) empties the pending buffer, zeroes the
// composed count and drops any result in flight.
`timescale 1ns / 1ps
`default_nettype none
module romaji_kana_composer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // char_code, raw_code
  input  wire logic [2:0]  s_tuser,  // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,  // kana_code, raw_text, raw_len, zero fill
  output logic [1:0]       m_tuser,  // kind
  output logic             m_tlast
);
  import rkc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t res;

  rkc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .stat(stat), .ctrl(ctrl)
  );

  rkc_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .in_cmd(s_tuser), .in_char(s_tdata[15:0]), .in_raw(s_tdata[31:16]),
    .out_res(res), .out_last(m_tlast), .out_valid(m_tvalid), .out_ready(m_tready)
  );

  assign m_tdata = {5'b0, res.rlen, res.raw, res.code};
  assign m_tuser = res.kind;

endmodule
`default_nettype wire

/* rtl/rkc_datapath.sv */
// Datapath of the romaji-to-kana composer: pending buffer, counters, rule evaluation,
// the result hold stage and the output register. Depends on rkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkc_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rkc_pkg::ctrl_t ctrl,
  output rkc_pkg::stat_t     stat,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [15:0]   in_char,
  input  wire logic [15:0]   in_raw,
  output rkc_pkg::res_t      out_res,
  output logic               out_last,
  output logic               out_valid,
  input  wire logic          out_ready
);
  import rkc_pkg::*;

  pend_t pend, pend_next;
  logic [2:0] cnt, cnt_next;
  logic [10:0] composed, composed_next;
  logic [2:0] op;
  logic [15:0] sym_char, sym_raw;
  logic first, first_next;
  logic fin, fin_next;
  logic k2_valid, k2_valid_next;
  logic [15:0] k2_code, k2_code_next;
  res_t hold, res;
  logic hold_valid;
  logic emits;
  logic out_free;
  look_t lk;
  pend_t dropped;
  logic [63:0] packed_raw;

  assign lk = rom_lookup(pend, cnt);
  assign packed_raw = pack_pending(pend, cnt);
  assign dropped = {16'h0000, pend[KEY_CHARS-1:1]};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    pend_next = pend;
    cnt_next = cnt;
    composed_next = composed;
    first_next = first;
    fin_next = fin;
    k2_valid_next = k2_valid;
    k2_code_next = k2_code;
    emits = 1'b0;
    res = '0;
    case (op)
      CMD_LETTER: begin
        if (k2_valid) begin
          emits = 1'b1;
          res.code = k2_code;
          k2_valid_next = 1'b0;
        end else if (cnt == 3'd0) begin
          fin_next = 1'b1;
        end else if (lk.hit) begin
          emits = 1'b1;
          res.code = lk.kana0;
          res.raw = packed_raw;
          res.rlen = cnt;
          cnt_next = 3'd0;
          k2_valid_next = lk.kana1 != 16'h0000;
          k2_code_next = lk.kana1;
        end else if (lk.prefix) begin
          fin_next = 1'b1;
        end else begin
          emits = 1'b1;
          res.rlen = 3'd1;
          if (cnt >= 3'd2 && pend[0] == pend[1] && pend[0] != CH_N &&
              !(pend[0] inside {16'h61, 16'h69, 16'h75, 16'h65, 16'h6F})) begin
            res.code = KANA_SMALL_TSU;
            res.raw = {48'h0, pend[0]};
          end else if (pend[0] == CH_N && cnt >= 3'd2) begin
            res.code = KANA_N;
            res.raw = {48'h0, CH_N};
          end else begin
            res.code = pend[0];
            res.raw = {48'h0, pend[0]};
          end
          pend_next = dropped;
          cnt_next = cnt - 3'd1;
        end
      end
      CMD_SYMBOL: begin
        emits = 1'b1;
        first_next = 1'b0;
        if (cnt == 3'd0) begin
          res.code = sym_char;
          res.raw = {48'h0, sym_raw};
          res.rlen = 3'd1;
          fin_next = 1'b1;
        end else if (first && cnt == 3'd1 && pend[0] == CH_N) begin
          res.code = KANA_N;
          res.raw = {48'h0, CH_N};
          res.rlen = 3'd1;
          cnt_next = 3'd0;
        end else begin
          res.code = pend[0];
          res.raw = first ? packed_raw : 64'h0;
          res.rlen = first ? cnt : 3'd0;
          pend_next = dropped;
          cnt_next = cnt - 3'd1;
        end
      end
      CMD_FLUSH: begin
        first_next = 1'b0;
        if (cnt == 3'd0) begin
          fin_next = 1'b1;
        end else begin
          emits = 1'b1;
          res.rlen = 3'd1;
          if (first && cnt == 3'd1 && pend[0] == CH_N) begin
            res.code = KANA_N;
            res.raw = {48'h0, CH_N};
            cnt_next = 3'd0;
          end else begin
            res.code = pend[0];
            res.raw = {48'h0, pend[0]};
            pend_next = dropped;
            cnt_next = cnt - 3'd1;
          end
        end
      end
      CMD_BACKSPACE: begin
        fin_next = 1'b1;
        if (cnt != 3'd0) begin
          cnt_next = cnt - 3'd1;
        end else if (composed != 11'd0) begin
          emits = 1'b1;
          res.kind = KIND_DELETE;
          composed_next = composed - 11'd1;
        end
      end
      CMD_CLEAR: begin
        emits = 1'b1;
        res.kind = KIND_CLEAR;
        cnt_next = 3'd0;
        composed_next = 11'd0;
        fin_next = 1'b1;
      end
      default: begin
        fin_next = 1'b1;
      end
    endcase
    if (emits && res.kind == KIND_APPEND && composed < COMPOSE_LIMIT) begin
      composed_next = composed + 11'd1;
    end
  end

  assign stat = '{fin: fin, emits: emits, hold_valid: hold_valid, out_free: out_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      composed <= 11'd0;
      op <= CMD_NONE;
      first <= 1'b0;
      fin <= 1'b1;
      k2_valid <= 1'b0;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        first <= 1'b1;
        fin <= 1'b0;
        k2_valid <= 1'b0;
        sym_char <= in_char;
        sym_raw <= in_raw;
        if (in_cmd == CMD_LETTER && cnt >= PEND_FULL) begin
          op <= CMD_NONE;
        end else begin
          op <= in_cmd;
        end
        if (in_cmd == CMD_LETTER && cnt < PEND_FULL) begin
          pend[cnt[1:0]] <= in_char;
          cnt <= cnt + 3'd1;
        end
      end else if (ctrl.step) begin
        pend <= pend_next;
        cnt <= cnt_next;
        composed <= composed_next;
        first <= first_next;
        fin <= fin_next;
        k2_valid <= k2_valid_next;
        k2_code <= k2_code_next;
        if (emits) begin
          hold <= res;
          hold_valid <= 1'b1;
        end
      end else if (ctrl.push_last) begin
        hold_valid <= 1'b0;
      end
      if (ctrl.step && emits && hold_valid) begin
        out_res <= hold;
        out_last <= 1'b0;
        out_valid <= 1'b1;
      end else if (ctrl.push_last) begin
        out_res <= hold;
        out_last <= 1'b1;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rkc_ctrl.sv */
// Controller of the romaji-to-kana composer: sequences loading, rule steps and the
// release of the final result. Depends on rkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkc_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rkc_pkg::stat_t stat,
  output rkc_pkg::ctrl_t   ctrl
);
  import rkc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.fin) begin
          state_next = S_FIN;
        end else if (!stat.emits || !stat.hold_valid || stat.out_free) begin
          ctrl.step = 1'b1;
        end
      end
      S_FIN: begin
        if (!stat.hold_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          ctrl.push_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/rkc_checker.sv */
// Port-level checker for the romaji-to-kana composer, bound to the top level.
// Depends on rkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);
  import rkc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second input taken while busy");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_CLEAR || m_tuser == KIND_DELETE) |-> m_tlast)
    else $error("delete or clear result not final");

endmodule

bind romaji_kana_composer_top rkc_checker u_rkc_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
